[rtl/lpl_pkg.sv]
`default_nettype none
package lpl_pkg;

	localparam int SW = 24;
	localparam int LVW = 28;
	localparam int CW = 24;
	localparam int GW = 21;
	localparam int PKW = 48;
	localparam int CFG_IW = 4;
	localparam int CNTW = 5;
	localparam int SQ_STEPS = 29;
	localparam int DIV_STEPS = 21;

	localparam logic [CFG_IW-1:0] REG_ATTACK = 4'd0;
	localparam logic [CFG_IW-1:0] REG_RELEASE = 4'd1;

	localparam logic [LVW-1:0] ONE_Q24 = 28'h100_0000;
	localparam logic [CW-1:0] ATTACK_RST = 24'd16777;
	localparam logic [CW-1:0] RELEASE_RST = 24'd1678;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQ_INIT,
		OP_SQ_STEP,
		OP_FILT_MUL,
		OP_FAST_ADD,
		OP_SLOW_ADD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SCALE,
		OP_LEAF,
		OP_SIB_RD,
		OP_SIB_WR,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sel_slow;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic last_level;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

[rtl/lookahead_peak_limiter.sv]
`default_nettype none
// Stereo look-ahead peak limiter. Each accepted frame produces one result: the frame taken
// LOOKAHEAD frames earlier, scaled by the gain, plus that gain in Q1.20. The time a frame
// takes is set by the bit-serial square root, the restoring divider for the gain and the
// leaf-to-root walk of the max tree (a sibling read, then a parent write, per level); a
// finished result may wait in the output register while the next frame is accepted. After
// reset the tree and delay memories are cleared, during which in_stall stays high.
// Coefficients are Q0.24 and should be written while no frame is in flight.
module lookahead_peak_limiter #(
	parameter int LOOKAHEAD = 128,
	parameter int LOOKAHEAD_LOG2 = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [lpl_pkg::SW-1:0] left_in,
	input  wire logic signed [lpl_pkg::SW-1:0] right_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [lpl_pkg::SW-1:0]      left_out,
	output logic signed [lpl_pkg::SW-1:0]      right_out,
	output logic [lpl_pkg::GW-1:0]             gain_now,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lpl_pkg::CFG_IW-1:0]    cfg_index,
	input  wire logic [lpl_pkg::CW-1:0]        cfg_data
);
	import lpl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpl_dp #(
		.LOOKAHEAD      (LOOKAHEAD),
		.LOOKAHEAD_LOG2 (LOOKAHEAD_LOG2)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.left_in   (left_in),
		.right_in  (right_in),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.left_out  (left_out),
		.right_out (right_out),
		.gain_now  (gain_now),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input side not busy after a transfer");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a frame in flight");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain_now <= GW'(21'h10_0000))
		else $error("gain above one");
`endif

endmodule
`default_nettype wire

[rtl/lpl_ctrl.sv]
`default_nettype none
module lpl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire lpl_pkg::sts_t sts,
	output lpl_pkg::cmd_t      cmd
);
	import lpl_pkg::*;

	typedef enum logic [14:0] {
		ST_CLEAR    = 15'b000_0000_0000_0001,
		ST_IDLE     = 15'b000_0000_0000_0010,
		ST_SQ_INIT  = 15'b000_0000_0000_0100,
		ST_SQRT     = 15'b000_0000_0000_1000,
		ST_FAST_MUL = 15'b000_0000_0001_0000,
		ST_FAST_ADD = 15'b000_0000_0010_0000,
		ST_SLOW_MUL = 15'b000_0000_0100_0000,
		ST_SLOW_ADD = 15'b000_0000_1000_0000,
		ST_DIV_INIT = 15'b000_0001_0000_0000,
		ST_DIV      = 15'b000_0010_0000_0000,
		ST_SCALE    = 15'b000_0100_0000_0000,
		ST_LEAF     = 15'b000_1000_0000_0000,
		ST_SIB_RD   = 15'b001_0000_0000_0000,
		ST_SIB_WR   = 15'b010_0000_0000_0000,
		ST_DONE     = 15'b100_0000_0000_0000
	} state_t;

	state_t st_q, st_nxt;
	logic [CNTW-1:0] cnt_q;

	always_comb begin
		st_nxt = st_q;
		cmd.op = OP_NONE;
		cmd.sel_slow = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				if (sts.clr_done) st_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					st_nxt = ST_SQ_INIT;
				end
			end
			ST_SQ_INIT: begin
				cmd.op = OP_SQ_INIT;
				st_nxt = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQ_STEP;
				if (cnt_q == CNTW'(SQ_STEPS - 1)) st_nxt = ST_FAST_MUL;
			end
			ST_FAST_MUL: begin
				cmd.op = OP_FILT_MUL;
				st_nxt = ST_FAST_ADD;
			end
			ST_FAST_ADD: begin
				cmd.op = OP_FAST_ADD;
				st_nxt = ST_SLOW_MUL;
			end
			ST_SLOW_MUL: begin
				cmd.op = OP_FILT_MUL;
				cmd.sel_slow = 1'b1;
				st_nxt = ST_SLOW_ADD;
			end
			ST_SLOW_ADD: begin
				cmd.op = OP_SLOW_ADD;
				st_nxt = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.op = OP_DIV_INIT;
				st_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == CNTW'(DIV_STEPS - 1)) st_nxt = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op = OP_SCALE;
				st_nxt = ST_LEAF;
			end
			ST_LEAF: begin
				cmd.op = OP_LEAF;
				st_nxt = ST_SIB_RD;
			end
			ST_SIB_RD: begin
				cmd.op = OP_SIB_RD;
				st_nxt = ST_SIB_WR;
			end
			ST_SIB_WR: begin
				cmd.op = OP_SIB_WR;
				st_nxt = sts.last_level ? ST_DONE : ST_SIB_RD;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.op = OP_OUT;
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			cnt_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (st_q == ST_SQRT || st_q == ST_DIV) cnt_q <= cnt_q + CNTW'(1);
			else cnt_q <= '0;
		end
	end

	assign in_stall = (st_q != ST_IDLE);

endmodule
`default_nettype wire

[rtl/lpl_dp.sv]
`default_nettype none
module lpl_dp #(
	parameter int LOOKAHEAD = 128,
	parameter int LOOKAHEAD_LOG2 = 7
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lpl_pkg::cmd_t                    cmd,
	output lpl_pkg::sts_t                         sts,
	input  wire logic signed [lpl_pkg::SW-1:0]    left_in,
	input  wire logic signed [lpl_pkg::SW-1:0]    right_in,
	input  wire logic                             cfg_we,
	input  wire logic [lpl_pkg::CFG_IW-1:0]       cfg_index,
	input  wire logic [lpl_pkg::CW-1:0]           cfg_data,
	output logic signed [lpl_pkg::SW-1:0]         left_out,
	output logic signed [lpl_pkg::SW-1:0]         right_out,
	output logic [lpl_pkg::GW-1:0]                gain_now,
	output logic                                  out_valid,
	input  wire logic                             out_stall
);
	import lpl_pkg::*;

	localparam int LW = LOOKAHEAD_LOG2;
	localparam int TW = LOOKAHEAD_LOG2 + 1;
	localparam int TSIZE = 2 * LOOKAHEAD;
	localparam logic [TW-1:0] ROOT_ADDR = TW'(TSIZE - 2);

	function automatic logic [SW-1:0] mag(input logic [SW-1:0] s);
		return s[SW-1] ? SW'(-s) : s;
	endfunction

	logic [PKW-1:0] tree_mem [TSIZE];
	logic [SW-1:0]  dl_mem [LOOKAHEAD];
	logic [SW-1:0]  dr_mem [LOOKAHEAD];

	logic [CW-1:0]  attack_q, release_q;
	logic [TW-1:0]  clr_q;
	logic           clr_done_q;
	logic [LW-1:0]  pos_q;
	logic [SW-1:0]  l_q, r_q, oldl_q, oldr_q;
	logic [PKW-1:0] trd_q, cur_q;
	logic [57:0]    rad_q;
	logic [29:0]    rem_q;
	logic [28:0]    res_q;
	logic [LVW-1:0] fast_q, slow_q;
	logic [52:0]    p1_q, p2_q;
	logic [LVW-1:0] dr_q;
	logic [20:0]    nlow_q;
	logic [GW-1:0]  q_q;
	logic [44:0]    sl_q, sr_q;
	logic [TW-1:0]  of_q, span_q;
	logic [LW-1:0]  node_q;
	logic           out_valid_q;
	logic [SW-1:0]  lo_q, ro_q;
	logic [GW-1:0]  go_q;

	logic [31:0]    rem_sh, trial;
	logic [LVW-1:0] level, fy, fx, fnew;
	logic [CW-1:0]  fc;
	logic [24:0]    fcm;
	logic [52:0]    p1, p2;
	logic [53:0]    fsum;
	logic [44:0]    dnum;
	logic [28:0]    dt;
	logic [SW-1:0]  pk, nml, nmr;
	logic [PKW-1:0] leaf, mx;
	logic [TW-1:0]  sib_addr, par_addr;
	logic [44:0]    rl, rr;
	logic           t_we, t_re;
	logic [TW-1:0]  t_waddr, t_raddr;
	logic [PKW-1:0] t_wdata;
	logic           last_level;

	// level and one-pole filter
	assign level = (res_q < 29'(ONE_Q24)) ? ONE_Q24 : res_q[LVW-1:0];
	assign fy = cmd.sel_slow ? slow_q : fast_q;
	assign fx = cmd.sel_slow ? fast_q : level;
	assign fc = cmd.sel_slow ? release_q : attack_q;
	assign fcm = 25'h100_0000 - {1'b0, fc};
	assign p1 = 53'(fcm) * 53'(fy);
	assign p2 = 53'(fc) * 53'(fx);
	assign fsum = 54'(p1_q) + 54'(p2_q) + 54'h80_0000;
	assign fnew = fsum[51:24];

	// square root and divider steps
	assign rem_sh = {rem_q, rad_q[57:56]};
	assign trial = {1'b0, res_q, 2'b01};
	assign dnum = 45'h1000_0000_0000 + 45'(slow_q >> 1);
	assign dt = {dr_q, nlow_q[20]};

	// tree update
	assign nml = mag(l_q);
	assign nmr = mag(r_q);
	assign pk = (nml > nmr) ? nml : nmr;
	assign leaf = PKW'(pk) * PKW'(pk);
	assign mx = (cur_q > trd_q) ? cur_q : trd_q;
	assign sib_addr = of_q + TW'({node_q[LW-1:1], ~node_q[0]});
	assign par_addr = of_q + span_q + TW'(node_q >> 1);
	assign last_level = (span_q == TW'(2));

	assign rl = sl_q + 45'h8_0000;
	assign rr = sr_q + 45'h8_0000;

	always_comb begin
		t_we = 1'b0;
		t_waddr = sib_addr;
		t_wdata = '0;
		if (!clr_done_q) begin
			t_we = 1'b1;
			t_waddr = clr_q;
		end else if (cmd.op == OP_LEAF) begin
			t_we = 1'b1;
			t_waddr = TW'(pos_q);
			t_wdata = leaf;
		end else if (cmd.op == OP_SIB_WR) begin
			t_we = 1'b1;
			t_waddr = par_addr;
			t_wdata = mx;
		end
		t_re = (cmd.op == OP_LOAD) || (cmd.op == OP_SIB_RD);
		t_raddr = (cmd.op == OP_LOAD) ? ROOT_ADDR : sib_addr;
	end

	always_ff @(posedge clk) begin
		if (t_we) tree_mem[t_waddr] <= t_wdata;
		if (t_re) trd_q <= tree_mem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (!clr_done_q) begin
			dl_mem[clr_q[LW-1:0]] <= '0;
			dr_mem[clr_q[LW-1:0]] <= '0;
		end else if (cmd.op == OP_LEAF) begin
			dl_mem[pos_q] <= l_q;
			dr_mem[pos_q] <= r_q;
		end
		if (cmd.op == OP_LOAD) begin
			oldl_q <= dl_mem[pos_q];
			oldr_q <= dr_mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= ATTACK_RST;
			release_q <= RELEASE_RST;
			clr_q <= '0;
			clr_done_q <= 1'b0;
			pos_q <= '0;
			fast_q <= ONE_Q24;
			slow_q <= ONE_Q24;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_ATTACK) attack_q <= cfg_data;
			if (cfg_we && cfg_index == REG_RELEASE) release_q <= cfg_data;
			if (!clr_done_q) begin
				clr_q <= clr_q + TW'(1);
				if (clr_q == ROOT_ADDR + TW'(1)) clr_done_q <= 1'b1;
			end
			if (cmd.op == OP_FAST_ADD) fast_q <= fnew;
			if (cmd.op == OP_SLOW_ADD) slow_q <= (fast_q > fnew) ? fast_q : fnew;
			if (cmd.op == OP_SIB_WR && last_level) pos_q <= pos_q + LW'(1);
			if (cmd.op == OP_OUT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				l_q <= left_in;
				r_q <= right_in;
			end
			OP_SQ_INIT: begin
				rad_q <= {1'b0, trd_q, 9'b0};
				rem_q <= '0;
				res_q <= '0;
			end
			OP_SQ_STEP: begin
				rad_q <= {rad_q[55:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q <= 30'(rem_sh - trial);
					res_q <= {res_q[27:0], 1'b1};
				end else begin
					rem_q <= rem_sh[29:0];
					res_q <= {res_q[27:0], 1'b0};
				end
			end
			OP_FILT_MUL: begin
				p1_q <= p1;
				p2_q <= p2;
			end
			OP_DIV_INIT: begin
				dr_q <= LVW'(dnum[44:21]);
				nlow_q <= dnum[20:0];
				q_q <= '0;
			end
			OP_DIV_STEP: begin
				nlow_q <= {nlow_q[19:0], 1'b0};
				if (dt >= {1'b0, slow_q}) begin
					dr_q <= LVW'(dt - {1'b0, slow_q});
					q_q <= {q_q[GW-2:0], 1'b1};
				end else begin
					dr_q <= dt[LVW-1:0];
					q_q <= {q_q[GW-2:0], 1'b0};
				end
			end
			OP_SCALE: begin
				sl_q <= 45'(mag(oldl_q)) * 45'(q_q);
				sr_q <= 45'(mag(oldr_q)) * 45'(q_q);
			end
			OP_LEAF: begin
				cur_q <= leaf;
				of_q <= '0;
				span_q <= TW'(LOOKAHEAD);
				node_q <= pos_q;
			end
			OP_SIB_WR: begin
				cur_q <= mx;
				of_q <= of_q + span_q;
				span_q <= span_q >> 1;
				node_q <= node_q >> 1;
			end
			OP_OUT: begin
				lo_q <= oldl_q[SW-1] ? SW'(-rl[43:20]) : rl[43:20];
				ro_q <= oldr_q[SW-1] ? SW'(-rr[43:20]) : rr[43:20];
				go_q <= q_q;
			end
			default: begin
			end
		endcase
	end

	assign sts = {clr_done_q, last_level, out_valid_q && out_stall};

	assign out_valid = out_valid_q;
	assign left_out = lo_q;
	assign right_out = ro_q;
	assign gain_now = go_q;

endmodule
`default_nettype wire

[verif/lookahead_peak_limiter_checker.sv]
`timescale 1ns / 1ps
module lookahead_peak_limiter_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic signed [lpl_pkg::SW-1:0] left_in,
	input  wire logic signed [lpl_pkg::SW-1:0] right_in,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic signed [lpl_pkg::SW-1:0] left_out,
	input  wire logic signed [lpl_pkg::SW-1:0] right_out,
	input  wire logic [lpl_pkg::GW-1:0]        gain_now,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [lpl_pkg::CFG_IW-1:0]    cfg_index,
	input  wire logic [lpl_pkg::CW-1:0]        cfg_data,
	output int                                 pending,
	output int                                 errors
);
	import lpl_pkg::*;

	localparam int LA = 128;
	localparam int LA_LOG2 = 7;

	typedef struct {
		logic signed [SW-1:0] left;
		logic signed [SW-1:0] right;
		logic [GW-1:0]        gain;
	} frame_t;

	frame_t               limited_q[$];
	logic [CW-1:0]        attack;
	logic [CW-1:0]        rel;
	logic signed [SW-1:0] hist_l[LA];
	logic signed [SW-1:0] hist_r[LA];
	logic [PKW-1:0]       peaks[2*LA];
	logic [63:0]          fast;
	logic [63:0]          slow;
	int                   wpos;

	assign pending = limited_q.size();

	function automatic logic [63:0] root_of(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] blend(input logic [63:0] y, input logic [63:0] x,
			input logic [CW-1:0] c);
		return (((64'd1 << 24) - c) * y + c * x + (64'd1 << 23)) >> 24;
	endfunction

	function automatic logic [SW-1:0] apply_gain(input logic signed [SW-1:0] s,
			input logic [63:0] g);
		logic [63:0] m;
		m = s < 0 ? 64'(-64'(s)) : 64'(s);
		m = (m * g + (64'd1 << 19)) >> 20;
		return s < 0 ? SW'(-m) : SW'(m);
	endfunction

	task automatic limit_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
		frame_t      f;
		logic [63:0] lvl, dv, g, ml, mr, pk, a, b;
		int          off, nxt, node;
		lvl = root_of((64'(peaks[2*LA-2]) << 9) & ((64'd1 << 57) - 1));
		if (lvl < ONE_Q24)
			lvl = ONE_Q24;
		fast = blend(fast, lvl, attack);
		slow = blend(slow, fast, rel);
		if (fast > slow)
			slow = fast;
		dv = slow < ONE_Q24 ? 64'(ONE_Q24) : slow;
		g = ((64'd1 << 44) + (dv >> 1)) / dv;
		f.left = apply_gain(hist_l[wpos], g);
		f.right = apply_gain(hist_r[wpos], g);
		f.gain = GW'(g);
		limited_q.push_back(f);
		hist_l[wpos] = l;
		hist_r[wpos] = r;
		ml = l < 0 ? 64'(-64'(l)) : 64'(l);
		mr = r < 0 ? 64'(-64'(r)) : 64'(r);
		pk = ml > mr ? ml : mr;
		peaks[wpos] = PKW'(pk * pk);
		off = 0;
		for (int i = 0; i < LA_LOG2; i++) begin
			nxt = off + (LA >> i);
			node = wpos >> i;
			a = peaks[off + node];
			b = peaks[off + (node ^ 1)];
			peaks[nxt + (wpos >> (i + 1))] = a > b ? a : b;
			off = nxt;
		end
		wpos = (wpos + 1) % LA;
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_t f;
		if (!arst_n) begin
			attack = ATTACK_RST;
			rel = RELEASE_RST;
			for (int i = 0; i < LA; i++) begin
				hist_l[i] = '0;
				hist_r[i] = '0;
			end
			for (int i = 0; i < 2*LA; i++)
				peaks[i] = '0;
			fast = ONE_Q24;
			slow = ONE_Q24;
			wpos = 0;
			limited_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ATTACK)
					attack = cfg_data;
				else if (cfg_index == REG_RELEASE)
					rel = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (limited_q.size() == 0) begin
					$display("unexpected output transfer at %0t", $realtime);
					errors++;
				end else begin
					f = limited_q.pop_front();
					if (left_out !== f.left)
						report("left_out", left_out, f.left);
					if (right_out !== f.right)
						report("right_out", right_out, f.right);
					if (gain_now !== f.gain)
						report("gain_now", gain_now, f.gain);
				end
			end
			if (in_valid && !in_stall)
				limit_frame(left_in, right_in);
		end
	end
endmodule

[verif/lookahead_peak_limiter_tb.sv]
`timescale 1ns / 1ps
module lookahead_peak_limiter_tb;
	import lpl_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam logic signed [SW-1:0] SMAX = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] SMIN = 24'sh800000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [SW-1:0] left_in;
	logic signed [SW-1:0] right_in;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [SW-1:0] left_out;
	logic signed [SW-1:0] right_out;
	logic [GW-1:0]        gain_now;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IW-1:0]    cfg_index;
	logic [CW-1:0]        cfg_data;
	int                   pending;
	int                   errors;
	int                   send_idle_pct;
	int                   recv_stall_pct;
	int                   quiet_cycles = 0;

	lookahead_peak_limiter uut (.*);

	lookahead_peak_limiter_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		left_in <= l;
		right_in <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic signed [SW-1:0] rand_sample(input int loudness);
		logic signed [SW-1:0] s;
		s = SW'($urandom);
		return s >>> loudness;
	endfunction

	task automatic random_frames(input int n);
		int loud;
		loud = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(15) == 0)
				loud = $urandom_range(12);
			if ($urandom_range(9) == 0)
				send_frame(SW'(0), rand_sample(loud));
			else if ($urandom_range(19) == 0)
				send_frame($urandom_range(1) ? SMAX : SMIN, rand_sample(loud));
			else
				send_frame(rand_sample(loud), rand_sample($urandom_range(12)));
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		left_in = '0;
		right_in = '0;
		cfg_valid = 0;
		cfg_index = REG_ATTACK;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed frames at reset coefficients
		send_frame(SMAX, SMAX);
		send_frame(SMIN, SMIN);
		send_frame(SMAX, SMIN);
		send_frame(SW'(0), SW'(0));
		send_frame(SW'(1), -SW'(1));
		send_frame(-SW'(1), SW'(1));
		send_frame(24'sh555555, 24'shAAAAAA);
		send_frame(24'shAAAAAA, 24'sh555555);
		send_frame(24'sh100000, -24'sh100000);
		send_frame(SW'(0), SMIN);
		drain();
		write_reg(REG_ATTACK, '1);
		write_reg(REG_RELEASE, '0);
		write_reg(CFG_IW'($urandom_range(15, 2)), '1);
		for (int i = 0; i < 10; i++)
			send_frame(i[0] ? SMAX : SW'(0), i[1] ? SMIN : SW'(3));
		drain();

		send_idle_pct = 11;
		recv_stall_pct = 71;
		write_reg(REG_RELEASE, '1);
		write_reg(REG_ATTACK, '0);
		random_frames(150);
		drain();
		write_reg(REG_ATTACK, CW'($urandom_range(300000, 1000)));
		write_reg(REG_RELEASE, CW'($urandom_range(60000, 100)));
		random_frames(100);

		drain();
		send_idle_pct = 71;
		recv_stall_pct = 11;
		write_reg(REG_ATTACK, ATTACK_RST);
		write_reg(REG_RELEASE, RELEASE_RST);
		random_frames(200);
		drain();
		write_reg(REG_ATTACK, CW'($urandom));
		write_reg(REG_RELEASE, CW'($urandom));
		write_reg(CFG_IW'($urandom_range(15, 2)), CW'($urandom));

		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_frames(250);
		drain();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
